// ----- sv/ple_pkg.sv -----
// Package with the shared types and codes of the positional list engine.
package ple_pkg;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_REM_FRONT = 3'd3,
    OP_REM_BACK  = 3'd4,
    OP_REM_AT    = 3'd5,
    OP_SEARCH    = 3'd6,
    OP_READ      = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] value;
    logic [6:0]         position;
  } item_in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [5:0]         found_index;
    logic [2:0]         status;
    logic [6:0]         list_length;
    logic               list_empty;
  } item_out_t;

endpackage

// ----- sv/ple_free_map.sv -----
// Free slot map with a lowest-free-slot search that runs one slot per cycle.
module ple_free_map #(
  parameter int unsigned CAPACITY = 64,
  localparam int unsigned SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          scan_start_i,
  output logic          scan_done_o,
  output logic [SW-1:0] scan_slot_o,
  input  logic          take_i,
  input  logic [SW-1:0] take_slot_i,
  input  logic          give_i,
  input  logic [SW-1:0] give_slot_i
);
  logic [CAPACITY-1:0] free_q;
  logic [SW-1:0]       idx_q;
  logic                run_q;

  assign scan_slot_o = idx_q;
  assign scan_done_o = run_q && free_q[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= '1;
      idx_q  <= '0;
      run_q  <= 1'b0;
    end else begin
      if (take_i) free_q[take_slot_i] <= 1'b0;
      if (give_i) free_q[give_slot_i] <= 1'b1;
      if (scan_start_i) begin
        idx_q <= '0;
        run_q <= 1'b1;
      end else if (run_q) begin
        if (free_q[idx_q]) begin
          run_q <= 1'b0;
        end else begin
          idx_q <= idx_q + SW'(1);
        end
      end
    end
  end
endmodule

// ----- sv/ple_slot_mem.sv -----
// Slot memory: value, forward and backward link per slot, registered read.
module ple_slot_mem #(
  parameter int unsigned CAPACITY = 64,
  localparam int unsigned SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic               clk_i,
  input  logic [SW-1:0]      rd_addr_i,
  output logic signed [31:0] rd_val_o,
  output logic [SW-1:0]      rd_fwd_o,
  output logic [SW-1:0]      rd_bwd_o,
  input  logic               we_val_i,
  input  logic               we_fwd_i,
  input  logic               we_bwd_i,
  input  logic [SW-1:0]      wr_addr_i,
  input  logic signed [31:0] wr_val_i,
  input  logic [SW-1:0]      wr_fwd_i,
  input  logic [SW-1:0]      wr_bwd_i
);
  logic signed [31:0] val_mem [CAPACITY];
  logic [SW-1:0]      fwd_mem [CAPACITY];
  logic [SW-1:0]      bwd_mem [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (we_val_i) val_mem[wr_addr_i] <= wr_val_i;
    if (we_fwd_i) fwd_mem[wr_addr_i] <= wr_fwd_i;
    if (we_bwd_i) bwd_mem[wr_addr_i] <= wr_bwd_i;
    rd_val_o <= val_mem[rd_addr_i];
    rd_fwd_o <= fwd_mem[rd_addr_i];
    rd_bwd_o <= bwd_mem[rd_addr_i];
  end
endmodule

// ----- sv/positional_list_engine.sv -----
// Top level of the positional list engine: command decode and list walker.
// The engine keeps a bounded circular doubly linked list of signed 32-bit
// values in a slot memory (value, forward link and backward link per slot,
// read through a registered port) plus a free map in flip-flops. One item is
// worked at a time: busy is high from the cycle after start is taken until
// the cycle of the result strobe, and in that cycle a new item may already be
// taken. Every item gives exactly one result, shown on result_o for a single
// cycle while done_o is high; the receiver cannot stall it. The walk to a
// position or the search follows forward links through the slot memory, one
// memory read per link. An insert first scans the free map for the lowest
// free slot, one slot per cycle.
module positional_list_engine #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  ple_pkg::item_in_t  item_i,
  output logic               done_o,
  output ple_pkg::item_out_t result_o
);
  import ple_pkg::*;

  localparam int unsigned SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > 7) ? CW : 7;

  typedef enum logic [3:0] {
    S_IDLE, S_ALLOC, S_WALK_RD, S_WALK_WT, S_INS_RD, S_INS_WT, S_INS_WR1,
    S_INS_WR2, S_REM_WT, S_REM_WR1, S_REM_WR2, S_SRCH_RD, S_SRCH_WT, S_DONE
  } state_e;

  state_e             state_q;
  op_e                op_q;
  logic signed [31:0] val_q;
  logic [CW-1:0]      pos_q;     // target index
  logic [CW-1:0]      step_q;    // links walked so far
  logic [SW-1:0]      cur_q;     // slot at the current index
  logic [SW-1:0]      new_q;     // newly allocated slot
  logic [SW-1:0]      nb_q;      // neighbor (before) slot
  logic [SW-1:0]      na_q;      // neighbor (after) slot
  logic [SW-1:0]      head_q;
  logic [CW-1:0]      count_q;
  item_out_t          res_q;
  logic               done_q;

  logic [SW-1:0]      rd_addr;
  logic signed [31:0] rd_val;
  logic [SW-1:0]      rd_fwd, rd_bwd;
  logic               we_val, we_fwd, we_bwd;
  logic [SW-1:0]      wr_addr, wr_fwd, wr_bwd;

  logic               scan_start, scan_done, take, give;
  logic [SW-1:0]      scan_slot;

  ple_slot_mem #(.CAPACITY(CAPACITY)) u_mem (
    .clk_i, .rd_addr_i(rd_addr), .rd_val_o(rd_val), .rd_fwd_o(rd_fwd),
    .rd_bwd_o(rd_bwd), .we_val_i(we_val), .we_fwd_i(we_fwd), .we_bwd_i(we_bwd),
    .wr_addr_i(wr_addr), .wr_val_i(val_q), .wr_fwd_i(wr_fwd), .wr_bwd_i(wr_bwd)
  );

  ple_free_map #(.CAPACITY(CAPACITY)) u_free (
    .clk_i, .rst_ni, .scan_start_i(scan_start), .scan_done_o(scan_done),
    .scan_slot_o(scan_slot), .take_i(take), .take_slot_i(scan_slot),
    .give_i(give), .give_slot_i(cur_q)
  );

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  // Position and length are compared at a common width so that no position
  // bits are lost whatever the capacity.
  logic [PW-1:0] in_pos_w, count_w;
  logic [CW-1:0] in_pos;
  logic          full;
  assign in_pos_w = PW'(item_i.position);
  assign count_w  = PW'(count_q);
  assign in_pos   = in_pos_w[CW-1:0];
  assign full     = (count_q == CW'(CAPACITY));

  // Memory and free map control, decoded from the state.
  always_comb begin
    rd_addr    = cur_q;
    we_val     = 1'b0;
    we_fwd     = 1'b0;
    we_bwd     = 1'b0;
    wr_addr    = new_q;
    wr_fwd     = na_q;
    wr_bwd     = nb_q;
    scan_start = start && !busy &&
                 (item_i.operation == OP_INS_FRONT || item_i.operation == OP_INS_BACK ||
                  item_i.operation == OP_INS_AT);
    take       = (state_q == S_ALLOC) && scan_done;
    give       = (state_q == S_REM_WT) && (op_q != OP_READ);
    unique case (state_q)
      S_INS_WR1: begin
        // New slot gets its value and both links.
        we_val = 1'b1; we_fwd = 1'b1; we_bwd = 1'b1;
      end
      S_INS_WR2: begin
        // before.fwd = new (or single-element self loop handled in WR1).
        we_fwd = 1'b1; wr_addr = nb_q; wr_fwd = new_q;
      end
      S_REM_WR1: begin
        we_fwd = 1'b1; wr_addr = nb_q; wr_fwd = na_q;
      end
      S_REM_WR2: begin
        we_bwd = 1'b1; wr_addr = na_q; wr_bwd = nb_q;
      end
      default: ;
    endcase
    // The after.bwd write of an insert goes out in S_INS_WT, where cur_q
    // still names the slot that will follow the new one.
    if (state_q == S_INS_WT && count_q != '0) begin
      we_bwd = 1'b1; wr_addr = cur_q; wr_bwd = new_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            op_q   <= op_e'(item_i.operation);
            val_q  <= item_i.value;
            cur_q  <= head_q;
            step_q <= '0;
            res_q  <= '0;
            unique case (op_e'(item_i.operation))
              OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
                pos_q <= (item_i.operation == OP_INS_FRONT) ? '0 :
                         (item_i.operation == OP_INS_BACK) ? count_q : in_pos;
                if (item_i.operation == OP_INS_AT && in_pos_w > count_w) begin
                  res_q.status <= ST_BADPOS; state_q <= S_DONE;
                end else if (full) begin
                  res_q.status <= ST_FULL; state_q <= S_DONE;
                end else begin
                  state_q <= S_ALLOC;
                end
              end
              OP_SEARCH: begin
                pos_q <= '0;
                if (count_q == '0) begin
                  res_q.status <= ST_EMPTY; state_q <= S_DONE;
                end else begin
                  state_q <= S_SRCH_RD;
                end
              end
              default: begin
                pos_q <= (item_i.operation == OP_REM_FRONT) ? '0 :
                         (item_i.operation == OP_REM_BACK) ? count_q - CW'(1) : in_pos;
                if (count_q == '0) begin
                  res_q.status <= ST_EMPTY; state_q <= S_DONE;
                end else if ((item_i.operation == OP_REM_AT ||
                              item_i.operation == OP_READ) && in_pos_w >= count_w) begin
                  res_q.status <= ST_BADPOS; state_q <= S_DONE;
                end else begin
                  state_q <= S_WALK_RD;
                end
              end
            endcase
          end
        end
        S_ALLOC: begin
          if (scan_done) begin
            new_q <= scan_slot;
            if (count_q == '0) begin
              na_q <= scan_slot; nb_q <= scan_slot; head_q <= scan_slot;
              state_q <= S_INS_WR1;
            end else begin
              state_q <= S_WALK_RD;
            end
          end
        end
        S_WALK_RD: begin
          // Position reached: cur_q is the target slot; read its links.
          if (step_q == pos_q || step_q == CW'(CAPACITY)) begin
            state_q <= (op_q == OP_INS_FRONT || op_q == OP_INS_BACK ||
                        op_q == OP_INS_AT) ? S_INS_WT : S_REM_WT;
          end else begin
            state_q <= S_WALK_WT;
          end
        end
        S_WALK_WT: begin
          cur_q   <= rd_fwd;
          step_q  <= step_q + CW'(1);
          state_q <= S_WALK_RD;
        end
        S_INS_WT: begin
          // rd_* now hold the links of the slot that will follow the new one.
          na_q    <= cur_q;
          nb_q    <= rd_bwd;
          if (pos_q == '0) head_q <= new_q;
          state_q <= S_INS_WR1;
        end
        S_INS_WR1: begin
          state_q <= (count_q == '0) ? S_INS_RD : S_INS_WR2;
        end
        S_INS_WR2: state_q <= S_INS_RD;
        S_INS_RD: begin
          count_q <= count_q + CW'(1);
          res_q.list_length <= 7'(count_q + CW'(1));
          res_q.list_empty  <= 1'b0;
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        S_REM_WT: begin
          res_q.read_value <= rd_val;
          nb_q <= rd_bwd;
          na_q <= rd_fwd;
          if (op_q == OP_READ) begin
            state_q <= S_DONE;
          end else begin
            if (pos_q == '0 && count_q != CW'(1)) head_q <= rd_fwd;
            state_q <= (count_q == CW'(1)) ? S_REM_WR2 : S_REM_WR1;
            count_q <= count_q - CW'(1);
          end
        end
        S_REM_WR1: state_q <= S_REM_WR2;
        S_REM_WR2: state_q <= S_DONE;
        S_SRCH_RD: state_q <= S_SRCH_WT;
        S_SRCH_WT: begin
          if (rd_val == val_q) begin
            res_q.found_index <= 6'(step_q);
            state_q <= S_DONE;
          end else if (step_q + CW'(1) == count_q) begin
            res_q.status <= ST_NOTFOUND;
            state_q <= S_DONE;
          end else begin
            cur_q   <= rd_fwd;
            step_q  <= step_q + CW'(1);
            state_q <= S_SRCH_RD;
          end
        end
        S_DONE: begin
          res_q.list_length <= 7'(count_q);
          res_q.list_empty  <= (count_q == '0);
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- test/list_checker.sv -----
// Checker that predicts and compares every result of the positional list engine.
module list_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  ple_pkg::item_in_t  item_i,
  input  logic               done_o,
  input  ple_pkg::item_out_t result_o,
  output int                 fail_count,
  output int                 pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import ple_pkg::*;

  localparam int unsigned SLOTS = 64;

  logic [31:0] cell_val [SLOTS];
  logic [5:0]  next_slot [SLOTS];
  logic [5:0]  prev_slot [SLOTS];
  logic        is_free [SLOTS];
  logic [5:0]  head;
  int unsigned count;

  item_out_t awaited_results[$];

  function automatic logic [5:0] slot_at(int unsigned n);
    logic [5:0] cur;
    cur = head;
    for (int unsigned i = 0; i < n && i < SLOTS; i++) cur = next_slot[cur];
    return cur;
  endfunction

  function automatic void link_in(int unsigned p, logic [31:0] v);
    logic [5:0] n;
    logic [5:0] after;
    logic [5:0] prior;
    n = 0;
    for (int s = SLOTS - 1; s >= 0; s--) if (is_free[s]) n = s[5:0];
    is_free[n] = 1'b0;
    cell_val[n] = v;
    if (count == 0) begin
      next_slot[n] = n;
      prev_slot[n] = n;
      head = n;
    end else begin
      after = slot_at(p);
      prior = prev_slot[after];
      next_slot[n] = after;
      prev_slot[n] = prior;
      next_slot[prior] = n;
      prev_slot[after] = n;
      if (p == 0) head = n;
    end
    count++;
  endfunction

  function automatic logic [31:0] unlink(int unsigned p);
    logic [5:0] node;
    logic [31:0] v;
    node = slot_at(p);
    v = cell_val[node];
    if (count > 1) begin
      next_slot[prev_slot[node]] = next_slot[node];
      prev_slot[next_slot[node]] = prev_slot[node];
      if (p == 0) head = next_slot[node];
    end
    is_free[node] = 1'b1;
    count--;
    return v;
  endfunction

  function automatic item_out_t apply_command(item_in_t it);
    item_out_t r;
    logic [5:0] cur;
    logic full;
    r = '0;
    r.status = ST_OK;
    full = (count >= SLOTS);
    case (op_e'(it.operation))
      OP_INS_FRONT, OP_INS_BACK: begin
        if (full) r.status = ST_FULL;
        else link_in(it.operation == OP_INS_FRONT ? 0 : count, it.value);
      end
      OP_INS_AT: begin
        if (it.position > count) r.status = ST_BADPOS;
        else if (full) r.status = ST_FULL;
        else link_in(it.position, it.value);
      end
      OP_REM_FRONT, OP_REM_BACK: begin
        if (count == 0) r.status = ST_EMPTY;
        else r.read_value = unlink(it.operation == OP_REM_FRONT ? 0 : count - 1);
      end
      OP_REM_AT: begin
        if (count == 0) r.status = ST_EMPTY;
        else if (it.position >= count) r.status = ST_BADPOS;
        else r.read_value = unlink(it.position);
      end
      OP_SEARCH: begin
        if (count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_NOTFOUND;
          cur = head;
          for (int unsigned i = 0; i < count; i++) begin
            if (cell_val[cur] == it.value) begin
              r.status = ST_OK;
              r.found_index = i[5:0];
              break;
            end
            cur = next_slot[cur];
          end
        end
      end
      default: begin
        if (count == 0) r.status = ST_EMPTY;
        else if (it.position >= count) r.status = ST_BADPOS;
        else r.read_value = cell_val[slot_at(it.position)];
      end
    endcase
    r.list_length = count[6:0];
    r.list_empty = (count == 0);
    return r;
  endfunction

  assign pending_count = awaited_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    item_out_t want;
    if (!rst_ni) begin
      fail_count <= 0;
      awaited_results.delete();
      for (int s = 0; s < SLOTS; s++) is_free[s] = 1'b1;
      head = 0;
      count = 0;
    end else begin
      if (done_o) begin
        if (awaited_results.size() == 0) begin
          if (fail_count < 10) $display("Unexpected result %p", result_o);
          fail_count <= fail_count + 1;
        end else begin
          want = awaited_results.pop_front();
          if (want !== result_o) begin
            if (fail_count < 10) $display("Mismatch: expected %p, got %p", want, result_o);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) awaited_results.push_back(apply_command(item_i));
    end
  end
endmodule

// ----- test/testbench.sv -----
// Top of the testbench: clock, reset, command stimulus and the verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ple_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic done_o;
  item_in_t item_i = '0;
  item_out_t result_o;
  int fail_count;
  int pending_count;
  int idle_cycles;
  int sender_gap_pct;
  int shadow_len;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  positional_list_engine dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .item_i(item_i), .done_o(done_o), .result_o(result_o)
  );

  list_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .item_i(item_i), .done_o(done_o), .result_o(result_o),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // The watchdog counts cycles with neither an accepted item nor a result.
  // The slowest item, an insert at the back of a nearly full list, scans
  // the free map and walks the whole list.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Sends one command and holds start until the engine takes it. Start
  // stays high between back-to-back items; the sender gap, when drawn,
  // lowers it for a random number of cycles first.
  task automatic send_command(op_e op, logic [31:0] v, logic [6:0] p);
    if ($urandom_range(99) < sender_gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= '{operation: op, value: v, position: p};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // Track the length loosely so that random positions mostly stay useful.
    case (op)
      OP_INS_FRONT, OP_INS_BACK: if (shadow_len < 64) shadow_len++;
      OP_INS_AT: if (p <= shadow_len && shadow_len < 64) shadow_len++;
      OP_REM_FRONT, OP_REM_BACK: if (shadow_len > 0) shadow_len--;
      OP_REM_AT: if (p < shadow_len) shadow_len--;
      default: ;
    endcase
  endtask

  // Waits until the checker has every expected result back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Random values come from a small pool half the time so searches hit.
  function automatic logic [31:0] pick_value();
    if ($urandom_range(1)) return 32'($urandom_range(7));
    return $urandom();
  endfunction

  task automatic random_phase(int n);
    int roll;
    logic [6:0] p;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      if ($urandom_range(9) == 0) p = $urandom_range(127);
      else p = 7'($urandom_range(shadow_len));
      // Bias toward growth while the list is short, shrink while long.
      if (roll < (shadow_len < 40 ? 45 : 25))
        send_command(op_e'($urandom_range(2)), pick_value(), p);
      else if (roll < 70)
        send_command(op_e'($urandom_range(3, 5)), pick_value(), p);
      else
        send_command(op_e'($urandom_range(6, 7)), pick_value(), p);
    end
  endtask

  initial begin
    shadow_len = 0;
    sender_gap_pct = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: operations on the empty list, then the value extremes.
    for (int o = 3; o <= 7; o++) send_command(op_e'(o), 32'h0, 7'd0);
    send_command(OP_INS_AT, 32'h1, 7'd1);
    send_command(OP_INS_BACK, 32'h8000_0000, 7'd0);
    send_command(OP_INS_FRONT, 32'h7FFF_FFFF, 7'd127);
    send_command(OP_INS_AT, 32'hFFFF_FFFF, 7'd2);
    send_command(OP_INS_AT, 32'h5555_AAAA, 7'd1);
    send_command(OP_SEARCH, 32'hFFFF_FFFF, 7'd0);
    send_command(OP_SEARCH, 32'h1234_5678, 7'd0);
    send_command(OP_READ, 32'h0, 7'd3);
    send_command(OP_READ, 32'h0, 7'd4);
    send_command(OP_REM_AT, 32'h0, 7'd127);
    send_command(OP_REM_AT, 32'h0, 7'd2);
    send_command(OP_REM_BACK, 32'h0, 7'd0);
    send_command(OP_REM_FRONT, 32'h0, 7'd0);
    send_command(OP_REM_FRONT, 32'h0, 7'd0);
    // The last element is gone now; the head keeps a stale slot.
    send_command(OP_READ, 32'h0, 7'd0);
    drain();

    // Fill to capacity, then overflow, then empty from the middle.
    for (int k = 0; k < 64; k++) send_command(OP_INS_BACK, $urandom(), 7'd0);
    send_command(OP_INS_FRONT, 32'h0, 7'd0);
    send_command(OP_INS_AT, 32'h0, 7'd64);
    send_command(OP_INS_AT, 32'h0, 7'd65);
    send_command(OP_READ, 32'h0, 7'd63);
    send_command(OP_SEARCH, 32'h0, 7'd0);
    for (int k = 0; k < 64; k++) send_command(OP_REM_AT, 32'h0, 7'(shadow_len / 2));

    sender_gap_pct = 23;
    random_phase(110);
    drain();
    sender_gap_pct = 81;
    random_phase(90);
    sender_gap_pct = 0;
    random_phase(100);
    drain();
    repeat (300) @(posedge clk_i);

    if (fail_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
